// ----- hw/rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the symbol frequency ranker: request action
// codes and the fixed field widths of the request and result channels.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Field widths of the request and result payloads.
  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int RANK_W   = 7;
  localparam int SYMBOL_W = 7;
  localparam int FREQ_W   = 16;
  localparam int USED_W   = 7;

  // Character code of the first counted symbol (space).
  localparam int FIRST_CODE = 32;

  // Request actions.
  typedef enum logic [ACTION_W-1:0] {
    ACT_COUNT = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

endpackage

// ----- hw/rtl/sfr_if.sv -----
// ----------------------------------------------------------------------------
// sfr_req_if / sfr_rsp_if
// Valid/ready channels of the symbol frequency ranker: the request channel
// (count, rank query, clear) and the result channel of a rank query.
// ----------------------------------------------------------------------------
interface sfr_req_if;
  logic                          valid;
  logic                          ready;
  logic [sfr_pkg::ACTION_W-1:0]  action;
  logic [sfr_pkg::CHAR_W-1:0]    character;
  logic [sfr_pkg::RANK_W-1:0]    rank;

  modport source (output valid, action, character, rank, input ready);
  modport sink   (input valid, action, character, rank, output ready);
endinterface

interface sfr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sfr_pkg::SYMBOL_W-1:0]  symbol;
  logic [sfr_pkg::FREQ_W-1:0]    frequency;
  logic                          found;
  logic [sfr_pkg::USED_W-1:0]    used_symbols;

  modport source (output valid, symbol, frequency, found, used_symbols, input ready);
  modport sink   (input valid, symbol, frequency, found, used_symbols, output ready);
endinterface

// ----- hw/rtl/sfr_ram.sv -----
// ----------------------------------------------------------------------------
// sfr_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module sfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 94
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/symbol_frequency_ranker.sv -----
// ----------------------------------------------------------------------------
// symbol_frequency_ranker
// Histogram of printable characters read back as a list ranked by ascending
// count, ties by ascending character code (first stage of a Huffman coder).
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake     Payload
//  req_i    in   valid/ready   action, character, rank
//  rsp_o    out  valid/ready   symbol, frequency, found, used_symbols
//
// A count request reads the count RAM, then writes the entry back in S_CNT;
// an ignored character, a clear or the unused action is done in S_IDLE. A rank
// query runs rank + 1 passes, or a single pass when the rank is at or above
// the number of used symbols: one pass over the single RAM read port per list
// position, each pass one read per entry, then the fold of the last read data
// and the close of the pass.
// Reset clears the per-entry valid bits at once, so no clearing pass is run.
// Requests are taken while a result waits in the output register; a query
// that finishes while that register is still full holds until it drains.
module symbol_frequency_ranker #(
  parameter int SYMBOLS    = 94,
  parameter int COUNT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfr_req_if.sink    req_i,
  sfr_rsp_if.source  rsp_o
);

  localparam int IDX_W = $clog2(SYMBOLS);
  localparam int UW    = $clog2(SYMBOLS + 1);
  localparam int CW    = (UW > sfr_pkg::RANK_W) ? UW : sfr_pkg::RANK_W;
  localparam int KEY_W = COUNT_BITS + IDX_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Controller states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CNT  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [SYMBOLS-1:0]           vld_q, vld_d;
  logic [IDX_W-1:0]             idx_q, idx_d;
  logic [IDX_W:0]               scan_q, scan_d;
  logic                         rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]             rd_idx_q, rd_idx_d;
  logic [sfr_pkg::RANK_W-1:0]   pass_q, pass_d;
  logic [sfr_pkg::RANK_W-1:0]   rank_q, rank_d;
  logic                         prev_vld_q, prev_vld_d;
  logic [KEY_W-1:0]             prev_key_q, prev_key_d;
  logic                         best_vld_q, best_vld_d;
  logic [KEY_W-1:0]             best_key_q, best_key_d;
  logic [UW-1:0]                used_q, used_d;

  logic                         rsp_vld_q, rsp_vld_d;
  logic [sfr_pkg::SYMBOL_W-1:0] symbol_q, symbol_d;
  logic [sfr_pkg::FREQ_W-1:0]   freq_q, freq_d;
  logic                         found_q, found_d;
  logic [sfr_pkg::USED_W-1:0]   used_out_q, used_out_d;

  logic                         acc;
  logic [8:0]                   ch_ext;
  logic                         in_range;
  logic [IDX_W-1:0]             ch_idx;
  logic                         ram_we;
  logic [IDX_W-1:0]             ram_raddr;
  logic [COUNT_BITS-1:0]        ram_rdata;
  logic [COUNT_BITS-1:0]        ram_wdata;
  logic [COUNT_BITS-1:0]        cnt_cur;
  logic [COUNT_BITS-1:0]        cnt_scan;
  logic [KEY_W-1:0]             scan_key;
  logic                         cand;
  logic                         issue;
  logic                         pass_end;
  logic                         miss;
  logic                         out_free;
  logic                         load;
  logic [COUNT_BITS-1:0]        best_cnt;
  logic [IDX_W-1:0]             best_idx;
  logic [9:0]                   sym_full;
  logic [31:0]                  freq_full;
  logic [15:0]                  used_full;

  // Request handshake: one request in flight at a time.
  assign req_i.ready = (state_q == S_IDLE);
  assign acc         = req_i.valid && req_i.ready;

  // Character decode into a histogram index.
  assign ch_ext   = 9'(req_i.character);
  assign in_range = (ch_ext >= 9'(sfr_pkg::FIRST_CODE)) &&
                    (ch_ext < 9'(sfr_pkg::FIRST_CODE + SYMBOLS));
  assign ch_idx   = IDX_W'(ch_ext - 9'(sfr_pkg::FIRST_CODE));

  // Count RAM: read while idle for a count, else at the scan address.
  assign ram_raddr = (state_q == S_IDLE) ? ch_idx : scan_q[IDX_W-1:0];
  assign ram_we    = (state_q == S_CNT);

  sfr_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (SYMBOLS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Saturating increment; an entry without its valid bit reads as zero.
  assign cnt_cur   = vld_q[idx_q] ? ram_rdata : '0;
  assign ram_wdata = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;

  // Scan compare: smallest (count, index) key above the previous pass's key.
  assign cnt_scan = vld_q[rd_idx_q] ? ram_rdata : '0;
  assign scan_key = {cnt_scan, rd_idx_q};
  assign cand     = rd_vld_q && (cnt_scan != '0) &&
                    (!prev_vld_q || (scan_key > prev_key_q)) &&
                    (!best_vld_q || (scan_key < best_key_q));

  assign issue    = (scan_q < (IDX_W + 1)'(SYMBOLS));
  assign pass_end = (state_q == S_SCAN) && !issue && !rd_vld_q;
  assign miss     = CW'(rank_q) >= CW'(used_q);
  assign out_free = !rsp_vld_q || rsp_o.ready;
  assign load     = pass_end && (miss || (pass_q == rank_q)) && out_free;

  // Result formatting, masked to the field widths.
  assign best_cnt  = best_key_q[KEY_W-1:IDX_W];
  assign best_idx  = best_key_q[IDX_W-1:0];
  assign sym_full  = 10'(best_idx) + 10'(sfr_pkg::FIRST_CODE);
  assign freq_full = 32'(best_cnt);
  assign used_full = 16'(used_q);

  // Next-state logic.
  always_comb begin
    state_d    = state_q;
    vld_d      = vld_q;
    idx_d      = idx_q;
    scan_d     = scan_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = scan_q[IDX_W-1:0];
    pass_d     = pass_q;
    rank_d     = rank_q;
    prev_vld_d = prev_vld_q;
    prev_key_d = prev_key_q;
    best_vld_d = best_vld_q;
    best_key_d = best_key_q;
    used_d     = used_q;
    rsp_vld_d  = rsp_vld_q && !rsp_o.ready;
    symbol_d   = symbol_q;
    freq_d     = freq_q;
    found_d    = found_q;
    used_out_d = used_out_q;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (req_i.action)
            sfr_pkg::ACT_COUNT: begin
              if (in_range) begin
                idx_d   = ch_idx;
                state_d = S_CNT;
              end
            end
            sfr_pkg::ACT_QUERY: begin
              rank_d     = req_i.rank;
              pass_d     = '0;
              prev_vld_d = 1'b0;
              best_vld_d = 1'b0;
              used_d     = '0;
              scan_d     = '0;
              state_d    = S_SCAN;
            end
            sfr_pkg::ACT_CLEAR: begin
              vld_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_CNT: begin
        vld_d[idx_q] = 1'b1;
        state_d      = S_IDLE;
      end
      S_SCAN: begin
        // Issue reads across the RAM, then fold each returned entry.
        if (issue) begin
          scan_d   = scan_q + 1'b1;
          rd_vld_d = 1'b1;
        end
        if (cand) begin
          best_vld_d = 1'b1;
          best_key_d = scan_key;
        end
        if (rd_vld_q && (cnt_scan != '0)) begin
          used_d = used_q + 1'b1;
        end
        // End of a pass: deliver the result or start the next pass.
        if (pass_end) begin
          if (miss || (pass_q == rank_q)) begin
            if (out_free) begin
              rsp_vld_d  = 1'b1;
              found_d    = !miss;
              symbol_d   = miss ? '0 : sym_full[sfr_pkg::SYMBOL_W-1:0];
              freq_d     = miss ? '0 : freq_full[sfr_pkg::FREQ_W-1:0];
              used_out_d = used_full[sfr_pkg::USED_W-1:0];
              state_d    = S_IDLE;
            end
          end else begin
            prev_vld_d = 1'b1;
            prev_key_d = best_key_q;
            best_vld_d = 1'b0;
            used_d     = '0;
            scan_d     = '0;
            pass_d     = pass_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      vld_q     <= vld_d;
      rd_vld_q  <= rd_vld_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    scan_q     <= scan_d;
    rd_idx_q   <= rd_idx_d;
    pass_q     <= pass_d;
    rank_q     <= rank_d;
    prev_vld_q <= prev_vld_d;
    prev_key_q <= prev_key_d;
    best_vld_q <= best_vld_d;
    best_key_q <= best_key_d;
    used_q     <= used_d;
    symbol_q   <= symbol_d;
    freq_q     <= freq_d;
    found_q    <= found_d;
    used_out_q <= used_out_d;
  end

  // Result channel.
  assign rsp_o.valid        = rsp_vld_q;
  assign rsp_o.symbol       = symbol_q;
  assign rsp_o.frequency    = freq_q;
  assign rsp_o.found        = found_q;
  assign rsp_o.used_symbols = used_out_q;

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && rsp_vld_q |-> rsp_o.ready)
    else $error("result overwritten before it was taken");

  // A miss reports a zero symbol and a zero frequency.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q && !found_q |-> (symbol_q == '0) && (freq_q == '0))
    else $error("not-found result carries a symbol or frequency");

  // A write-back only ever follows the read issued for an accepted count.
  a_cnt_after_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CNT |-> $past(state_q) == S_IDLE)
    else $error("count write-back without a preceding read");

endmodule
